// ===== rtl/fixed_point_to_decimal_text_top_assert.svh =====
// Assertion macros used by the checker file of the decimal text converter.
// No dependencies; include by bare file name.
`ifndef FIXED_POINT_TO_DECIMAL_TEXT_TOP_ASSERT_SVH
`define FIXED_POINT_TO_DECIMAL_TEXT_TOP_ASSERT_SVH

// Checked on every rising edge, suspended while reset is asserted.
`define FTDT_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, also while reset is asserted.
`define FTDT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/ftdt_pkg.sv =====
// Package of the fixed-point to decimal text converter: widths, character codes,
// queue entry type and state encodings. No dependencies.
`default_nettype none

package ftdt_pkg;

	localparam int VALUE_W       = 63;
	localparam int CHAR_W        = 6;
	localparam int BCD_DIGITS    = 19;
	localparam int DIGIT_IDX_W   = 5;
	localparam int SHIFT_W       = 64;
	localparam int BITS_PER_STEP = 4;
	localparam int CONV_CYCLES   = SHIFT_W / BITS_PER_STEP;
	localparam int CNT_W         = 4;
	localparam int QUEUE_DEPTH   = 2;
	localparam int QPTR_W        = 1;
	localparam int QCNT_W        = 2;

	localparam logic [CHAR_W-1:0] CHAR_ZERO = 6'd48;
	localparam logic [CHAR_W-1:0] CHAR_NINE = 6'd57;
	localparam logic [CHAR_W-1:0] CHAR_DOT  = 6'd46;

	typedef logic [BCD_DIGITS-1:0][3:0] digits_t;

	// One converted value, ready for the character emitter.
	typedef struct packed {
		digits_t                digits;
		logic [DIGIT_IDX_W-1:0] int_top;
		logic [DIGIT_IDX_W-1:0] frac_low;
		logic                   frac_nz;
	} entry_t;

	typedef struct packed {
		logic not_empty;
		logic full;
	} queue_status_t;

	typedef enum logic [1:0] {
		FR_IDLE,
		FR_CONV,
		FR_PUSH
	} front_state_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_INT,
		BK_DOT,
		BK_FRAC
	} back_state_t;

endpackage

`default_nettype wire

// ===== rtl/fixed_point_to_decimal_text_top.sv =====
// Top level of the fixed-point to decimal text converter.
// Depends on ftdt_pkg, ftdt_front, ftdt_queue and ftdt_back.
//
//   Channel   Handshake                     Payload
//   input     start / busy                  scaled_value[62:0]
//   result    strobe (one cycle per char)   text_char[5:0], is_last
//
// A value is taken when start is high and busy is low. The front converts it
// to BCD, then classifies the digits and queues them, and takes no new value
// until it has queued the last one and the two-entry queue has room. The back
// emits one character per cycle, up to 20 per value. Reset clears all control
// state asynchronously; the receiver cannot stall, so results are never held.
`default_nettype none

module fixed_point_to_decimal_text_top #(
	parameter int FRACTION_DIGITS = 4
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic [ftdt_pkg::VALUE_W-1:0]  scaled_value,
	output logic                               strobe,
	output logic [ftdt_pkg::CHAR_W-1:0]        text_char,
	output logic                               is_last
);

	logic                        push;
	logic                        pop;
	ftdt_pkg::entry_t            push_data;
	ftdt_pkg::entry_t            pop_data;
	ftdt_pkg::queue_status_t     q_status;

	ftdt_front #(
		.FRACTION_DIGITS (FRACTION_DIGITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.scaled_value (scaled_value),
		.q_status     (q_status),
		.busy         (busy),
		.push         (push),
		.push_data    (push_data)
	);

	ftdt_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.status    (q_status)
	);

	ftdt_back #(
		.FRACTION_DIGITS (FRACTION_DIGITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_status  (q_status),
		.pop_data  (pop_data),
		.pop       (pop),
		.strobe    (strobe),
		.text_char (text_char),
		.is_last   (is_last)
	);

endmodule

`default_nettype wire

// ===== rtl/ftdt_queue.sv =====
// Two-entry queue of converted values between the front and back parts.
// Depends on ftdt_pkg.
`default_nettype none

module ftdt_queue (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    push,
	input  wire ftdt_pkg::entry_t        push_data,
	input  wire logic                    pop,
	output ftdt_pkg::entry_t             pop_data,
	output ftdt_pkg::queue_status_t      status
);

	ftdt_pkg::entry_t                    slot_q [ftdt_pkg::QUEUE_DEPTH];
	logic [ftdt_pkg::QPTR_W-1:0]         wr_ptr_q;
	logic [ftdt_pkg::QPTR_W-1:0]         rd_ptr_q;
	logic [ftdt_pkg::QCNT_W-1:0]         count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign pop_data         = slot_q[rd_ptr_q];
	assign status.not_empty = (count_q != '0);
	assign status.full      = (count_q == ftdt_pkg::QCNT_W'(ftdt_pkg::QUEUE_DEPTH));

endmodule

`default_nettype wire

// ===== rtl/ftdt_front.sv =====
// Front part: accepts a value, converts it to 19 BCD digits by shift-and-add-3,
// four bits a cycle, then classifies the digits and pushes them. Depends on ftdt_pkg.
`default_nettype none

module ftdt_front #(
	parameter int FRACTION_DIGITS = 4
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [ftdt_pkg::VALUE_W-1:0]  scaled_value,
	input  wire ftdt_pkg::queue_status_t       q_status,
	output logic                               busy,
	output logic                               push,
	output ftdt_pkg::entry_t                   push_data
);

	localparam int BCD_W = ftdt_pkg::BCD_DIGITS * 4;
	localparam logic [ftdt_pkg::DIGIT_IDX_W-1:0] FD_IDX =
		ftdt_pkg::DIGIT_IDX_W'(FRACTION_DIGITS);

	ftdt_pkg::front_state_t              state_q, state_d;
	logic [ftdt_pkg::CNT_W-1:0]          cnt_q;
	logic [ftdt_pkg::SHIFT_W-1:0]        shift_q;
	logic [BCD_W-1:0]                    bcd_q;
	logic [ftdt_pkg::SHIFT_W-1:0]        shift_next;
	logic [BCD_W-1:0]                    bcd_next;
	logic                                accept;
	logic                                last_step;
	ftdt_pkg::digits_t                   digits;
	logic [ftdt_pkg::DIGIT_IDX_W-1:0]    int_top;
	logic [ftdt_pkg::DIGIT_IDX_W-1:0]    frac_low;
	logic                                frac_nz;

	assign last_step = (cnt_q == ftdt_pkg::CNT_W'(ftdt_pkg::CONV_CYCLES - 1));

	// Four shift-and-add-3 steps per cycle; the digit corrections are independent.
	always_comb begin
		bcd_next   = bcd_q;
		shift_next = shift_q;
		for (int s = 0; s < ftdt_pkg::BITS_PER_STEP; s++) begin
			for (int d = 0; d < ftdt_pkg::BCD_DIGITS; d++) begin
				if (bcd_next[d*4 +: 4] >= 4'd5) begin
					bcd_next[d*4 +: 4] = bcd_next[d*4 +: 4] + 4'd3;
				end
			end
			bcd_next   = {bcd_next[BCD_W-2:0], shift_next[ftdt_pkg::SHIFT_W-1]};
			shift_next = {shift_next[ftdt_pkg::SHIFT_W-2:0], 1'b0};
		end
	end

	// Highest nonzero integer digit, and lowest nonzero fraction digit.
	always_comb begin
		digits   = bcd_q;
		int_top  = FD_IDX;
		frac_low = '0;
		frac_nz  = 1'b0;
		for (int i = FRACTION_DIGITS; i < ftdt_pkg::BCD_DIGITS; i++) begin
			if (digits[i] != 4'd0) begin
				int_top = ftdt_pkg::DIGIT_IDX_W'(i);
			end
		end
		for (int i = FRACTION_DIGITS - 1; i >= 0; i--) begin
			if (digits[i] != 4'd0) begin
				frac_low = ftdt_pkg::DIGIT_IDX_W'(i);
				frac_nz  = 1'b1;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ftdt_pkg::FR_IDLE: begin
				if (accept) begin
					state_d = ftdt_pkg::FR_CONV;
				end
			end
			ftdt_pkg::FR_CONV: begin
				if (last_step) begin
					state_d = ftdt_pkg::FR_PUSH;
				end
			end
			ftdt_pkg::FR_PUSH: begin
				state_d = ftdt_pkg::FR_IDLE;
			end
			default: begin
				state_d = ftdt_pkg::FR_IDLE;
			end
		endcase
	end

	// A value is only taken when the queue has room, so the push never waits.
	always_comb begin
		busy = 1'b1;
		push = 1'b0;
		unique case (state_q)
			ftdt_pkg::FR_IDLE: begin
				busy = q_status.full;
			end
			ftdt_pkg::FR_CONV: begin
				busy = 1'b1;
			end
			ftdt_pkg::FR_PUSH: begin
				push = 1'b1;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

	assign accept = start && !busy;

	assign push_data.digits   = digits;
	assign push_data.int_top  = int_top;
	assign push_data.frac_low = frac_low;
	assign push_data.frac_nz  = frac_nz;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ftdt_pkg::FR_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				cnt_q <= '0;
			end else if (state_q == ftdt_pkg::FR_CONV) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			shift_q <= {{(ftdt_pkg::SHIFT_W - ftdt_pkg::VALUE_W){1'b0}}, scaled_value};
			bcd_q   <= '0;
		end else if (state_q == ftdt_pkg::FR_CONV) begin
			shift_q <= shift_next;
			bcd_q   <= bcd_next;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/ftdt_back.sv =====
// Back part: takes converted values from the queue and emits one character per
// cycle, integer digits, then an optional dot and fraction digits. Depends on ftdt_pkg.
`default_nettype none

module ftdt_back #(
	parameter int FRACTION_DIGITS = 4
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire ftdt_pkg::queue_status_t       q_status,
	input  wire ftdt_pkg::entry_t              pop_data,
	output logic                               pop,
	output logic                               strobe,
	output logic [ftdt_pkg::CHAR_W-1:0]        text_char,
	output logic                               is_last
);

	localparam logic [ftdt_pkg::DIGIT_IDX_W-1:0] FD_IDX =
		ftdt_pkg::DIGIT_IDX_W'(FRACTION_DIGITS);
	localparam logic [ftdt_pkg::DIGIT_IDX_W-1:0] FD_TOP_IDX =
		ftdt_pkg::DIGIT_IDX_W'(FRACTION_DIGITS - 1);

	ftdt_pkg::back_state_t               state_q, state_d;
	ftdt_pkg::digits_t                   digits_q;
	logic [ftdt_pkg::DIGIT_IDX_W-1:0]    idx_q;
	logic [ftdt_pkg::DIGIT_IDX_W-1:0]    frac_low_q;
	logic                                frac_nz_q;
	logic [3:0]                          cur_digit;
	logic [ftdt_pkg::CHAR_W-1:0]         digit_char;
	logic                                emit;
	logic [ftdt_pkg::CHAR_W-1:0]         emit_char;
	logic                                emit_last;
	logic                                finish;
	logic                                strobe_q;
	logic [ftdt_pkg::CHAR_W-1:0]         text_char_q;
	logic                                is_last_q;

	assign cur_digit  = digits_q[idx_q];
	assign digit_char = ftdt_pkg::CHAR_ZERO + {2'b00, cur_digit};

	always_comb begin
		emit      = 1'b0;
		emit_char = ftdt_pkg::CHAR_ZERO;
		emit_last = 1'b0;
		finish    = 1'b0;
		unique case (state_q)
			ftdt_pkg::BK_IDLE: begin
				emit = 1'b0;
			end
			ftdt_pkg::BK_INT: begin
				emit      = 1'b1;
				emit_char = digit_char;
				finish    = (idx_q == FD_IDX) && !frac_nz_q;
				emit_last = finish;
			end
			ftdt_pkg::BK_DOT: begin
				emit      = 1'b1;
				emit_char = ftdt_pkg::CHAR_DOT;
			end
			ftdt_pkg::BK_FRAC: begin
				emit      = 1'b1;
				emit_char = digit_char;
				finish    = (idx_q == frac_low_q);
				emit_last = finish;
			end
			default: begin
				emit = 1'b0;
			end
		endcase
		// The next value is loaded in the cycle that ends the current one.
		pop = q_status.not_empty && ((state_q == ftdt_pkg::BK_IDLE) || finish);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ftdt_pkg::BK_IDLE: begin
				if (pop) begin
					state_d = ftdt_pkg::BK_INT;
				end
			end
			ftdt_pkg::BK_INT: begin
				if (idx_q == FD_IDX) begin
					if (frac_nz_q) begin
						state_d = ftdt_pkg::BK_DOT;
					end else begin
						state_d = pop ? ftdt_pkg::BK_INT : ftdt_pkg::BK_IDLE;
					end
				end
			end
			ftdt_pkg::BK_DOT: begin
				state_d = ftdt_pkg::BK_FRAC;
			end
			ftdt_pkg::BK_FRAC: begin
				if (finish) begin
					state_d = pop ? ftdt_pkg::BK_INT : ftdt_pkg::BK_IDLE;
				end
			end
			default: begin
				state_d = ftdt_pkg::BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ftdt_pkg::BK_IDLE;
			strobe_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			strobe_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		text_char_q <= emit_char;
		is_last_q   <= emit_last;
		if (pop) begin
			digits_q   <= pop_data.digits;
			idx_q      <= pop_data.int_top;
			frac_low_q <= pop_data.frac_low;
			frac_nz_q  <= pop_data.frac_nz;
		end else begin
			case (state_q)
				ftdt_pkg::BK_INT: begin
					if (idx_q != FD_IDX) begin
						idx_q <= idx_q - 1'b1;
					end
				end
				ftdt_pkg::BK_DOT: begin
					idx_q <= FD_TOP_IDX;
				end
				ftdt_pkg::BK_FRAC: begin
					if (!finish) begin
						idx_q <= idx_q - 1'b1;
					end
				end
				default: begin
					idx_q <= idx_q;
				end
			endcase
		end
	end

	assign strobe    = strobe_q;
	assign text_char = text_char_q;
	assign is_last   = is_last_q;

endmodule

`default_nettype wire

// ===== rtl/ftdt_checker.sv =====
// Port-level checker for the decimal text converter, bound to the top level.
// Depends on ftdt_pkg and fixed_point_to_decimal_text_top_assert.svh.
`default_nettype none

`include "fixed_point_to_decimal_text_top_assert.svh"

module ftdt_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          start,
	input wire logic                          busy,
	input wire logic                          strobe,
	input wire logic [ftdt_pkg::CHAR_W-1:0]   text_char,
	input wire logic                          is_last
);

	logic [2:0] pending_q;
	logic       accept;
	logic       done;
	logic       is_dot;
	logic       is_digit;

	assign accept   = start && !busy;
	assign done     = strobe && is_last;
	assign is_dot   = (text_char == ftdt_pkg::CHAR_DOT);
	assign is_digit = (text_char >= ftdt_pkg::CHAR_ZERO) && (text_char <= ftdt_pkg::CHAR_NINE);

	// Values accepted whose final character has not yet appeared.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (accept && !done) begin
			pending_q <= pending_q + 1'b1;
		end else if (done && !accept) begin
			pending_q <= pending_q - 1'b1;
		end
	end

	`FTDT_ASSERT(a_char_range, clk, arst_n, strobe |-> (is_dot || is_digit), "bad character code")
	`FTDT_ASSERT(a_no_orphan_char, clk, arst_n, strobe |-> (pending_q != 3'd0), "orphan character")
	`FTDT_ASSERT(a_dot_followed, clk, arst_n, (strobe && is_dot) |-> (!is_last ##1 (strobe && !is_dot)), "lone dot")
	`FTDT_ASSERT(a_busy_after_accept, clk, arst_n, accept |=> busy, "transaction taken during conversion")
	`FTDT_ASSERT_ALWAYS(a_quiet_in_reset, clk, !arst_n |=> !strobe, "strobe during reset")

endmodule

bind fixed_point_to_decimal_text_top ftdt_checker u_ftdt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.strobe    (strobe),
	.text_char (text_char),
	.is_last   (is_last)
);

`default_nettype wire
